FILE: sv/msw_pkg.sv
// ----------------------------------------------------------------------------
// msw_pkg: shared types and constants of the motion stall watchdog
// Block state codes, item mode codes, register map and control state type.
// ----------------------------------------------------------------------------
package msw_pkg;

	// block state codes carried in the result item
	localparam logic [1:0] BS_CLEAR     = 2'd0;
	localparam logic [1:0] BS_POSSIBLE  = 2'd1;
	localparam logic [1:0] BS_BLOCKED   = 2'd2;
	localparam logic [1:0] BS_RESOLVING = 2'd3;

	// item modes
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_FORCE  = 1'b1;

	// register field widths and reset values
	localparam int RADIUS_W  = 23;
	localparam int TIMEOUT_W = 16;
	localparam int TIME_W    = 32;
	localparam int FRAME_W   = 16;
	localparam int DATA_W    = 32;
	localparam logic [RADIUS_W-1:0]  RADIUS_RST  = RADIUS_W'(160);
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(800);

	// register map: two 32-bit registers at byte offsets 0 and 4
	localparam int ADDR_W = 3;
	localparam logic REG_RADIUS  = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	// top level control sequence
	typedef enum logic [3:0] {
		FS_IDLE = 4'b0001,
		FS_SCAN = 4'b0010,
		FS_RAD  = 4'b0100,
		FS_DONE = 4'b1000
	} msw_fsm_t;

endpackage

FILE: sv/motion_stall_watchdog.sv
// ----------------------------------------------------------------------------
// motion_stall_watchdog: stall detector for a moving object
// Keeps a history of recent positions and raises blocked when the bounds of
// that history stay small for longer than a timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_valid/in_stall) are either position samples or force
//   items; every accepted item gives exactly one result item on
//   out_valid/out_stall carrying block_state, blocked_event and
//   below_threshold.
//   A moving sample writes the position memory and then scans all
//   HISTORY_DEPTH entries through its single read port, one per cycle,
//   followed by a five-step squared-extent test on one shared squarer;
//   the next item is taken in the cycle after the result is registered.
//   Force items and samples while not moving skip the scan and the test
//   and go straight to the done state, where their result is registered
//   once the output register is free.
//   One item is worked on at a time; in_stall stays high until its result
//   is in the output register.
//   A result waiting on out_stall holds its values; the next item may be
//   accepted and worked on meanwhile, and it finishes once the output
//   register is free.
//   Reset clears the history to zeros, the state to not blocked, the
//   clear time stamp to -1 and the registers to 160 and 800.
//   Registers (APB, byte address 0 and 4): stall_radius, stall_timeout_ms.
// ----------------------------------------------------------------------------
module motion_stall_watchdog import msw_pkg::*; #(
	parameter int HISTORY_DEPTH = 32,
	parameter int POS_BITS      = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ADDR_W-1:0]          paddr,
	input  logic [DATA_W-1:0]          pwdata,
	output logic [DATA_W-1:0]          prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       mode,
	input  logic                       moving,
	input  logic signed [POS_BITS-1:0] pos_x,
	input  logic signed [POS_BITS-1:0] pos_y,
	input  logic signed [POS_BITS-1:0] pos_z,
	input  logic signed [TIME_W-1:0]   now_ms,
	input  logic [FRAME_W-1:0]         frame_ms,
	input  logic [1:0]                 forced_state,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 block_state,
	output logic                       blocked_event,
	output logic                       below_threshold
);

	logic [RADIUS_W-1:0]  radius_q;
	logic [TIMEOUT_W-1:0] timeout_q;

	msw_fsm_t fsm_q;

	logic               mode_q;
	logic               samp_q;
	logic [TIME_W-1:0]  now_q;
	logic [FRAME_W-1:0] frame_q;
	logic [1:0]         forced_q;

	logic [1:0]        st_q;
	logic [TIME_W-1:0] last_q;

	logic              out_valid_q;
	logic [1:0]        out_state_q;
	logic              out_event_q;
	logic              out_below_q;

	logic              acc;
	logic              ring_start;
	logic              ring_done;
	logic [POS_BITS:0] ext_x;
	logic [POS_BITS:0] ext_y;
	logic [POS_BITS:0] ext_z;
	logic              rad_done;
	logic              rad_below;
	logic              commit;
	logic              below;
	logic              timed_out;
	logic [1:0]        nxt_st;
	logic [TIME_W-1:0] nxt_last;
	logic              nxt_event;
	logic              reg_sel;
	logic              wr_en;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= RADIUS_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_RADIUS:  radius_q  <= pwdata[RADIUS_W-1:0];
				REG_TIMEOUT: timeout_q <= pwdata[TIMEOUT_W-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_RADIUS:  prdata = DATA_W'(radius_q);
			REG_TIMEOUT: prdata = DATA_W'(timeout_q);
			default:     prdata = '0;
		endcase
	end

	// input handshake
	assign in_stall   = fsm_q != FS_IDLE;
	assign acc        = in_valid && !in_stall;
	assign ring_start = acc && mode == MODE_SAMPLE && moving;
	assign commit     = fsm_q == FS_DONE && (!out_valid_q || !out_stall);

	// history memory and bounds scan
	msw_ring #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.POS_BITS      (POS_BITS)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ring_start),
		.pos_x  (pos_x),
		.pos_y  (pos_y),
		.pos_z  (pos_z),
		.done   (ring_done),
		.ext_x  (ext_x),
		.ext_y  (ext_y),
		.ext_z  (ext_z)
	);

	// squared bounds test
	msw_radius #(
		.POS_BITS (POS_BITS)
	) u_radius (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ring_done),
		.radius (radius_q),
		.ext_x  (ext_x),
		.ext_y  (ext_y),
		.ext_z  (ext_z),
		.done   (rad_done),
		.below  (rad_below)
	);

	// item fields kept for the final update
	always_ff @(posedge clk) begin
		if (acc) begin
			mode_q   <= mode;
			now_q    <= now_ms;
			frame_q  <= frame_ms;
			forced_q <= forced_state;
		end
	end

	// control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q  <= FS_IDLE;
			samp_q <= 1'b0;
		end else begin
			unique case (fsm_q)
				FS_IDLE: begin
					if (acc) begin
						samp_q <= ring_start;
						fsm_q  <= ring_start ? FS_SCAN : FS_DONE;
					end
				end
				FS_SCAN: begin
					if (ring_done) fsm_q <= FS_RAD;
				end
				FS_RAD: begin
					if (rad_done) fsm_q <= FS_DONE;
				end
				FS_DONE: begin
					if (commit) fsm_q <= FS_IDLE;
				end
				default: fsm_q <= FS_IDLE;
			endcase
		end
	end

	// next block state
	assign below     = samp_q && rad_below;
	assign timed_out = $signed({{2{now_q[TIME_W-1]}}, now_q}) >
		$signed({{2{last_q[TIME_W-1]}}, last_q}) + $signed({2'b00, 16'(0), timeout_q});

	always_comb begin
		nxt_st    = st_q;
		nxt_last  = last_q;
		nxt_event = 1'b0;
		if (mode_q == MODE_FORCE) begin
			nxt_st = forced_q;
			if (forced_q == BS_CLEAR) nxt_last = now_q;
		end else if (samp_q) begin
			case (st_q)
				BS_CLEAR: begin
					if (below) begin
						nxt_st   = BS_POSSIBLE;
						nxt_last = now_q - TIME_W'(frame_q);
					end
				end
				BS_POSSIBLE: begin
					if (!below) begin
						nxt_st = BS_CLEAR;
					end else if (timed_out) begin
						nxt_st    = BS_BLOCKED;
						nxt_event = 1'b1;
					end
				end
				BS_BLOCKED: begin
					if (!below) nxt_st = BS_CLEAR;
				end
				default: ;
			endcase
		end
	end

	// block state and time stamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= BS_CLEAR;
			last_q <= '1;
		end else if (commit) begin
			st_q   <= nxt_st;
			last_q <= nxt_last;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_state_q <= nxt_st;
			out_event_q <= nxt_event;
			out_below_q <= below;
		end
	end

	assign out_valid       = out_valid_q;
	assign block_state     = out_state_q;
	assign blocked_event   = out_event_q;
	assign below_threshold = out_below_q;

endmodule

FILE: sv/msw_ring.sv
// ----------------------------------------------------------------------------
// msw_ring: position history memory and bounds scan
// Writes one position per start, then walks every entry once to form the
// per-axis min and max. Entries not yet written read as zero.
// ----------------------------------------------------------------------------
module msw_ring import msw_pkg::*; #(
	parameter int HISTORY_DEPTH = 32,
	parameter int POS_BITS      = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [POS_BITS-1:0] pos_x,
	input  logic signed [POS_BITS-1:0] pos_y,
	input  logic signed [POS_BITS-1:0] pos_z,
	output logic                       done,
	output logic        [POS_BITS:0]   ext_x,
	output logic        [POS_BITS:0]   ext_y,
	output logic        [POS_BITS:0]   ext_z
);

	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int ENT_W = 3 * POS_BITS;

	logic [ENT_W-1:0] mem [HISTORY_DEPTH];

	logic [IDX_W-1:0] wr_idx_q;
	logic [CNT_W-1:0] fill_q;
	logic             scan_q;
	logic [IDX_W-1:0] cnt_q;
	logic             done_q;

	logic [ENT_W-1:0] rd_data_s1;
	logic             rd_vld_s1;
	logic             rd_inb_s1;
	logic             rd_first_s1;
	logic             rd_last_s1;

	logic signed [POS_BITS-1:0] lo_q [3];
	logic signed [POS_BITS-1:0] hi_q [3];
	logic signed [POS_BITS-1:0] val  [3];

	// memory: one write on start, one read per scan cycle
	always_ff @(posedge clk) begin
		if (start) begin
			mem[wr_idx_q] <= {pos_z, pos_y, pos_x};
		end
		if (scan_q) begin
			rd_data_s1 <= mem[cnt_q];
		end
	end

	// write pointer, fill count and scan sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q    <= '0;
			fill_q      <= '0;
			scan_q      <= 1'b0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_inb_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			rd_vld_s1   <= scan_q;
			rd_inb_s1   <= CNT_W'(cnt_q) < fill_q;
			rd_first_s1 <= cnt_q == '0;
			rd_last_s1  <= cnt_q == IDX_W'(HISTORY_DEPTH - 1);
			done_q      <= rd_vld_s1 && rd_last_s1;
			if (start) begin
				if (wr_idx_q == IDX_W'(HISTORY_DEPTH - 1)) begin
					wr_idx_q <= '0;
				end else begin
					wr_idx_q <= wr_idx_q + 1'b1;
				end
				if (fill_q != CNT_W'(HISTORY_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
				scan_q <= 1'b1;
				cnt_q  <= '0;
			end else if (scan_q) begin
				if (cnt_q == IDX_W'(HISTORY_DEPTH - 1)) begin
					scan_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// unwritten entries count as zero
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			val[a] = rd_inb_s1 ? $signed(rd_data_s1[a*POS_BITS +: POS_BITS]) : '0;
		end
	end

	// running min and max per axis
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			for (int a = 0; a < 3; a++) begin
				if (rd_first_s1 || val[a] < lo_q[a]) begin
					lo_q[a] <= val[a];
				end
				if (rd_first_s1 || val[a] > hi_q[a]) begin
					hi_q[a] <= val[a];
				end
			end
		end
	end

	// extents, held until the next start
	assign ext_x = {hi_q[0][POS_BITS-1], hi_q[0]} - {lo_q[0][POS_BITS-1], lo_q[0]};
	assign ext_y = {hi_q[1][POS_BITS-1], hi_q[1]} - {lo_q[1][POS_BITS-1], lo_q[1]};
	assign ext_z = {hi_q[2][POS_BITS-1], hi_q[2]} - {lo_q[2][POS_BITS-1], lo_q[2]};
	assign done  = done_q;

endmodule

FILE: sv/msw_radius.sv
// ----------------------------------------------------------------------------
// msw_radius: squared bounds test
// One shared 32x32 squarer forms (2*radius)^2 and the three squared
// extents in turn; a saturating sum is compared against the limit.
// ----------------------------------------------------------------------------
module msw_radius import msw_pkg::*; #(
	parameter int POS_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [RADIUS_W-1:0] radius,
	input  logic [POS_BITS:0]   ext_x,
	input  logic [POS_BITS:0]   ext_y,
	input  logic [POS_BITS:0]   ext_z,
	output logic                done,
	output logic                below
);

	logic [2:0]  step_q;
	logic        run_q;
	logic        done_q;
	logic        below_q;
	logic [63:0] mul_s1;
	logic        big_s1;
	logic [63:0] lim2_q;
	logic [63:0] sum_q;

	logic [63:0] opnd;
	logic        big;
	logic [31:0] op32;
	logic [63:0] sum_in;
	logic [64:0] add;
	logic [63:0] nsum;

	// operand select: limit first, then the extents
	always_comb begin
		case (step_q)
			3'd0:    opnd = 64'({radius, 1'b0});
			3'd1:    opnd = 64'(ext_x);
			3'd2:    opnd = 64'(ext_y);
			3'd3:    opnd = 64'(ext_z);
			default: opnd = '0;
		endcase
		big    = opnd > 64'hFFFF_FFFF;
		op32   = opnd[31:0];
		sum_in = (step_q == 3'd2) ? '0 : sum_q;
		add    = {1'b0, sum_in} + {1'b0, mul_s1};
		nsum   = (big_s1 || add[64]) ? '1 : add[63:0];
	end

	// squarer stage
	always_ff @(posedge clk) begin
		mul_s1 <= {32'd0, op32} * {32'd0, op32};
		big_s1 <= big;
		if (run_q && step_q == 3'd1) begin
			lim2_q <= mul_s1;
		end
		if (run_q && step_q >= 3'd2) begin
			sum_q <= nsum;
		end
		if (run_q && step_q == 3'd4) begin
			below_q <= nsum < lim2_q;
		end
	end

	// step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && run_q && step_q == 3'd4;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				if (step_q == 3'd4) begin
					run_q <= 1'b0;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign done  = done_q;
	assign below = below_q;

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for motion_stall_watchdog
// Drives position samples and force items through the valid/stall input,
// predicts every result from an internal copy of the history ring and the
// blocked state machine, and checks each result item field by field.
// Directed rows come first, then random motion episodes under several
// register settings, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
	import msw_pkg::*;

	localparam int DEPTH        = 32;
	localparam int POS_W        = 24;
	localparam int POS_MIN      = -(1 << (POS_W - 1));
	localparam int POS_MAX      = (1 << (POS_W - 1)) - 1;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 280;
	localparam int N_PHASES     = 6;
	localparam int LIMIT_CYCLES = 700000;

	typedef struct {
		logic                     mode;
		logic                     moving;
		logic signed [POS_W-1:0]  px, py, pz;
		logic signed [TIME_W-1:0] now;
		logic [FRAME_W-1:0]       frame;
		logic [1:0]               fst;
	} sample_t;

	typedef struct packed {
		logic [1:0] st;
		logic       ev;
		logic       below;
	} verdict_t;

	typedef struct {
		sample_t  it;
		bit       typed;
		verdict_t want;
	} step_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       psel, penable, pwrite;
	logic [ADDR_W-1:0]          paddr;
	logic [DATA_W-1:0]          pwdata;
	logic [DATA_W-1:0]          prdata;
	logic                       pready;
	logic                       in_valid;
	logic                       in_stall;
	logic                       mode, moving;
	logic signed [POS_W-1:0]    pos_x, pos_y, pos_z;
	logic signed [TIME_W-1:0]   now_ms;
	logic [FRAME_W-1:0]         frame_ms;
	logic [1:0]                 forced_state;
	logic                       out_valid;
	logic                       out_stall;
	logic [1:0]                 block_state;
	logic                       blocked_event;
	logic                       below_threshold;

	// predictor state
	logic signed [POS_W-1:0]    hist [DEPTH][3];
	logic [$clog2(DEPTH)-1:0]   hist_wr;
	logic [1:0]                 wd_state;
	logic [TIME_W-1:0]          clear_stamp;
	logic [RADIUS_W-1:0]        radius_cfg;
	logic [TIMEOUT_W-1:0]       timeout_cfg;

	verdict_t                   verdict_q [$];
	step_row_t                  rows [$];
	int                         mismatches = 0;
	bit                         hold_req = 1'b0;
	int                         burst_left = 0;

	// motion episode generator state
	int                         g_cx, g_cy, g_cz, g_spread, g_left = 0;
	logic [TIME_W-1:0]          g_t = '0;

	motion_stall_watchdog #(.HISTORY_DEPTH(DEPTH), .POS_BITS(POS_W)) u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .moving(moving), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.now_ms(now_ms), .frame_ms(frame_ms), .forced_state(forced_state),
		.out_valid(out_valid), .out_stall(out_stall),
		.block_state(block_state), .blocked_event(blocked_event),
		.below_threshold(below_threshold)
	);

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// run limit
	initial begin
		#(20 * LIMIT_CYCLES);
		$display("*** FAILED ***");
		$finish;
	end

	// next state of the watchdog and the result item of one accepted item
	function automatic verdict_t predict_verdict(input sample_t s);
		verdict_t                v;
		logic                    b;
		logic signed [POS_W-1:0] lo, hi;
		logic [63:0]             ext, sum, lim;
		longint                  now_w, stamp_w;
		int                      ax, i;
		v = '0;
		if (s.mode == MODE_FORCE) begin
			wd_state = s.fst;
			if (wd_state == BS_CLEAR)
				clear_stamp = s.now;
		end else if (s.moving) begin
			hist[hist_wr][0] = s.px;
			hist[hist_wr][1] = s.py;
			hist[hist_wr][2] = s.pz;
			hist_wr = hist_wr + 1'b1;
			// bounds of the whole ring, squared half-diagonal test
			sum = '0;
			for (ax = 0; ax < 3; ax++) begin
				lo = hist[0][ax];
				hi = hist[0][ax];
				for (i = 1; i < DEPTH; i++) begin
					if (hist[i][ax] < lo) lo = hist[i][ax];
					if (hist[i][ax] > hi) hi = hist[i][ax];
				end
				ext = 64'(longint'(hi) - longint'(lo));
				sum = sum + ext * ext;
			end
			lim = 64'(radius_cfg) * 64'd2;
			b = (sum < lim * lim);
			v.below = b;
			case (wd_state)
				BS_CLEAR: begin
					if (b) begin
						wd_state = BS_POSSIBLE;
						clear_stamp = s.now - TIME_W'(s.frame);
					end
				end
				BS_POSSIBLE: begin
					if (b) begin
						// exact compare, no wrap of the stamp plus timeout
						now_w = longint'(s.now);
						stamp_w = longint'($signed(clear_stamp));
						if (now_w > stamp_w + longint'(timeout_cfg)) begin
							wd_state = BS_BLOCKED;
							v.ev = 1'b1;
						end
					end else begin
						wd_state = BS_CLEAR;
					end
				end
				BS_BLOCKED: begin
					if (!b)
						wd_state = BS_CLEAR;
				end
				default: begin
				end
			endcase
		end
		v.st = wd_state;
		return v;
	endfunction

	// one row of the directed table
	function automatic void add_row(input logic md, input logic mv, input int x, input int y,
			input int z, input logic [TIME_W-1:0] t, input int f, input logic [1:0] fs,
			input bit typed, input logic [1:0] st, input logic ev, input logic bl);
		step_row_t r;
		r.it.mode = md;
		r.it.moving = mv;
		r.it.px = POS_W'(x);
		r.it.py = POS_W'(y);
		r.it.pz = POS_W'(z);
		r.it.now = t;
		r.it.frame = FRAME_W'(f);
		r.it.fst = fs;
		r.typed = typed;
		r.want.st = st;
		r.want.ev = ev;
		r.want.below = bl;
		rows.insert(rows.size(), r);
	endfunction

	// coordinate near an episode center, or anywhere for a wild episode
	function automatic logic signed [POS_W-1:0] near_pos(input int c);
		int v;
		if (g_spread < 0)
			return POS_W'($urandom());
		v = c + int'($urandom_range(0, 2 * g_spread)) - g_spread;
		if (v < POS_MIN) v = POS_MIN;
		if (v > POS_MAX) v = POS_MAX;
		return POS_W'(v);
	endfunction

	// random item: mostly moving samples of one motion episode
	function automatic sample_t next_item();
		sample_t s;
		int      r;
		if (g_left == 0) begin
			g_left = $urandom_range(10, 90);
			g_cx = int'($signed(POS_W'($urandom())));
			g_cy = int'($signed(POS_W'($urandom())));
			g_cz = int'($signed(POS_W'($urandom())));
			case ($urandom_range(0, 9))
				0, 1:    g_spread = $urandom_range(0, 3);
				2, 3, 4: g_spread = $urandom_range(4, 60);
				5, 6:    g_spread = $urandom_range(61, 600);
				7:       g_spread = $urandom_range(601, 6000);
				8:       g_spread = -1;
				default: begin
					g_spread = $urandom_range(0, 60);
					g_cx = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
				end
			endcase
			case ($urandom_range(0, 7))
				0:       g_t = $urandom();
				1:       g_t = 32'h7FFF_FFFF - $urandom_range(0, 3000);
				default: begin
				end
			endcase
		end
		g_left--;
		r = $urandom_range(0, 99);
		s.mode = MODE_SAMPLE;
		s.moving = 1'b1;
		s.fst = 2'($urandom());
		s.frame = ($urandom_range(0, 19) == 0) ? FRAME_W'($urandom()) :
			FRAME_W'($urandom_range(1, 50));
		g_t = g_t + TIME_W'(s.frame);
		s.now = g_t;
		s.px = POS_W'($urandom());
		s.py = POS_W'($urandom());
		s.pz = POS_W'($urandom());
		if (r < 3) begin
			s.mode = 1'($urandom());
			s.moving = 1'($urandom());
			s.now = $urandom();
		end else if (r < 8) begin
			s.mode = MODE_FORCE;
		end else if (r < 13) begin
			s.moving = 1'b0;
		end else begin
			s.px = near_pos(g_cx);
			s.py = near_pos(g_cy);
			s.pz = near_pos(g_cz);
		end
		return s;
	endfunction

	// offer one item, record its expected result once it is taken
	task automatic drive_item(input sample_t s, input bit typed, input verdict_t want);
		verdict_t v;
		in_valid <= 1'b1;
		mode <= s.mode;
		moving <= s.moving;
		pos_x <= s.px;
		pos_y <= s.py;
		pos_z <= s.pz;
		now_ms <= s.now;
		frame_ms <= s.frame;
		forced_state <= s.fst;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		v = predict_verdict(s);
		verdict_q.insert(verdict_q.size(), typed ? want : v);
		@(posedge clk);
	endtask

	// sender bursts with random gaps
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat (($urandom_range(0, 15) == 0) ? $urandom_range(40, 120) :
					$urandom_range(1, 8))
				@(posedge clk);
			burst_left = $urandom_range(0, 40);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic reg_sel, input logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(reg_sel));
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == REG_RADIUS)
			radius_cfg = val[RADIUS_W-1:0];
		else
			timeout_cfg = val[TIMEOUT_W-1:0];
		@(posedge clk);
	endtask

	// receiver stall patterns and the long hold-off
	initial begin
		int left, smode, cyc, hold_left;
		left = 0;
		smode = 0;
		cyc = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (left == 0) begin
					left = $urandom_range(20, 200);
					smode = $urandom_range(0, 3);
				end
				left--;
				case (smode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 3) == 0);
					2:       out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ((cyc % 7) < 3);
				endcase
			end
		end
	end

	// result checker
	initial begin
		verdict_t got, want;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.st = block_state;
				got.ev = blocked_event;
				got.below = below_threshold;
				if (verdict_q.size() == 0) begin
					mismatches++;
					$display("%0t: result item with none expected: state %0d event %0d below %0d",
						$time, got.st, got.ev, got.below);
				end else begin
					want = verdict_q.pop_front();
					if (got.st !== want.st) begin
						mismatches++;
						$display("%0t: block_state expected %0d got %0d", $time, want.st, got.st);
					end
					if (got.ev !== want.ev) begin
						mismatches++;
						$display("%0t: blocked_event expected %0d got %0d", $time, want.ev, got.ev);
					end
					if (got.below !== want.below) begin
						mismatches++;
						$display("%0t: below_threshold expected %0d got %0d",
							$time, want.below, got.below);
					end
				end
			end
		end
	end

	// main sequence
	initial begin
		logic [31:0] rad_set [N_PHASES];
		logic [31:0] to_set [N_PHASES];
		int          p, n;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		mode <= MODE_SAMPLE;
		moving <= 1'b0;
		pos_x <= '0;
		pos_y <= '0;
		pos_z <= '0;
		now_ms <= '0;
		frame_ms <= '0;
		forced_state <= BS_CLEAR;

		for (n = 0; n < DEPTH; n++) begin
			hist[n][0] = '0;
			hist[n][1] = '0;
			hist[n][2] = '0;
		end
		hist_wr = '0;
		wd_state = BS_CLEAR;
		clear_stamp = '1;
		radius_cfg = RADIUS_RST;
		timeout_cfg = TIMEOUT_RST;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset settings: radius 160, timeout 800
		add_row(MODE_SAMPLE, 1'b0, 77, -9, 4, 32'd3, 16, BS_BLOCKED,
			1, BS_CLEAR, 1'b0, 1'b0);
		add_row(MODE_FORCE, 1'b1, 1, 2, 3, 32'd0, 0, BS_POSSIBLE,
			1, BS_POSSIBLE, 1'b0, 1'b0);
		add_row(MODE_FORCE, 1'b0, 0, 0, 0, 32'd4, 0, BS_RESOLVING,
			1, BS_RESOLVING, 1'b0, 1'b0);
		// resolving ignores the test
		add_row(MODE_SAMPLE, 1'b1, 0, 0, 0, 32'd10, 16, BS_CLEAR,
			1, BS_RESOLVING, 1'b0, 1'b1);
		add_row(MODE_FORCE, 1'b1, 9, 9, 9, 32'd1000, 0, BS_CLEAR,
			1, BS_CLEAR, 1'b0, 1'b0);
		// enter possible, stamp 1984, then the timeout boundary
		add_row(MODE_SAMPLE, 1'b1, 5, -5, 5, 32'd2000, 16, BS_CLEAR,
			1, BS_POSSIBLE, 1'b0, 1'b1);
		add_row(MODE_SAMPLE, 1'b1, 0, 0, 0, 32'd2784, 16, BS_CLEAR,
			1, BS_POSSIBLE, 1'b0, 1'b1);
		add_row(MODE_SAMPLE, 1'b1, 1, 1, 1, 32'd2785, 16, BS_CLEAR,
			1, BS_BLOCKED, 1'b1, 1'b1);
		add_row(MODE_SAMPLE, 1'b1, 2, 2, 2, 32'd3000, 16, BS_CLEAR,
			1, BS_BLOCKED, 1'b0, 1'b1);
		// stamp plus timeout past the top of the signed range
		add_row(MODE_FORCE, 1'b0, 0, 0, 0, 32'h7FFF_FF00, 0, BS_CLEAR,
			1, BS_CLEAR, 1'b0, 1'b0);
		add_row(MODE_FORCE, 1'b0, 0, 0, 0, 32'd5, 0, BS_POSSIBLE,
			1, BS_POSSIBLE, 1'b0, 1'b0);
		add_row(MODE_SAMPLE, 1'b1, 0, 0, 0, 32'h7FFF_FFFF, 0, BS_CLEAR,
			0, BS_CLEAR, 1'b0, 1'b0);
		add_row(MODE_SAMPLE, 1'b1, -3, 0, 3, 32'h8000_0000, 1, BS_CLEAR,
			0, BS_CLEAR, 1'b0, 1'b0);
		// stamp wraps when the frame is subtracted
		add_row(MODE_FORCE, 1'b1, 0, 0, 0, 32'd100, 0, BS_CLEAR,
			1, BS_CLEAR, 1'b0, 1'b0);
		add_row(MODE_SAMPLE, 1'b1, 3, 3, 3, 32'h8000_0000, 65535, BS_CLEAR,
			0, BS_CLEAR, 1'b0, 1'b0);
		add_row(MODE_SAMPLE, 1'b1, 0, 0, 0, 32'h7FFF_FFFF, 16, BS_CLEAR,
			0, BS_CLEAR, 1'b0, 1'b0);
		// position extremes: huge extents never count as stalled
		add_row(MODE_SAMPLE, 1'b1, POS_MAX, 0, 0, 32'h7FFF_FFFF, 16, BS_CLEAR,
			1, BS_CLEAR, 1'b0, 1'b0);
		add_row(MODE_SAMPLE, 1'b1, POS_MIN, POS_MIN, POS_MIN, 32'd50, 16,
			BS_CLEAR, 1, BS_CLEAR, 1'b0, 1'b0);
		add_row(MODE_SAMPLE, 1'b1, POS_MAX, POS_MAX, POS_MAX, 32'd60, 16,
			BS_CLEAR, 1, BS_CLEAR, 1'b0, 1'b0);
		add_row(MODE_FORCE, 1'b0, 0, 0, 0, 32'd7, 0, BS_BLOCKED,
			1, BS_BLOCKED, 1'b0, 1'b0);
		add_row(MODE_SAMPLE, 1'b0, POS_MIN, POS_MAX, POS_MIN, 32'h8000_0000,
			65535, BS_RESOLVING, 1, BS_BLOCKED, 1'b0, 1'b0);
		add_row(MODE_SAMPLE, 1'b1, 0, 0, 0, 32'd70, 16, BS_CLEAR,
			1, BS_CLEAR, 1'b0, 1'b0);
		add_row(MODE_FORCE, 1'b1, 0, 0, 0, 32'd80, 0, BS_RESOLVING,
			1, BS_RESOLVING, 1'b0, 1'b0);
		add_row(MODE_SAMPLE, 1'b1, 1, 2, 3, 32'd90, 16, BS_CLEAR,
			1, BS_RESOLVING, 1'b0, 1'b0);
		add_row(MODE_FORCE, 1'b0, 0, 0, 0, 32'hFFFF_FFFF, 0, BS_CLEAR,
			1, BS_CLEAR, 1'b0, 1'b0);

		foreach (rows[n]) begin
			drive_item(rows[n].it, rows[n].typed, rows[n].want);
			pace();
		end
		drain();

		// register settings per phase, extremes among them
		rad_set[0] = 32'(RADIUS_RST);
		to_set[0] = 32'(TIMEOUT_RST);
		rad_set[1] = 32'd0;
		to_set[1] = 32'd0;
		rad_set[2] = 32'h007F_FFFF;
		to_set[2] = 32'h0000_FFFF;
		rad_set[3] = $urandom_range(16, 4000);
		to_set[3] = $urandom_range(0, 2000);
		rad_set[4] = $urandom_range(16, 600);
		to_set[4] = $urandom_range(100, 1500);
		rad_set[5] = 32'd1;
		to_set[5] = 32'd0;

		for (p = 0; p < N_PHASES; p++) begin
			apb_write(REG_RADIUS, rad_set[p]);
			apb_write(REG_TIMEOUT, to_set[p]);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold-off while items keep coming
				if (n == 100)
					hold_req = 1'b1;
				// sender waits for every pending result
				if (n == 200)
					drain();
				drive_item(next_item(), 1'b0, '0);
				pace();
			end
			drain();
		end

		repeat (60) @(posedge clk);
		if (mismatches == 0 && verdict_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
